// ===== design/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the exposure statistics check
// Holds the register map, the verdict codes, the reset values of the
// threshold registers and the threshold bundle handed to the evaluator.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int CFG_DATA_W      = 10;
	localparam int CFG_INDEX_W     = 2;
	localparam int PERMILLE_W      = 10;
	localparam int LEVEL_W         = 8;
	localparam int NUM_CH          = 3;
	localparam int PERMILLE_SCALE  = 1000;

	localparam logic [LEVEL_W-1:0] LEVEL_DARK   = 8'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT = 8'd255;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_CLIP_FLOOR   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STRONG_CLIP  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MEAN_LOW     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MEAN_HIGH    = 2'd3;

	// register reset values
	localparam logic [PERMILLE_W-1:0] CLIP_FLOOR_RST  = 10'd10;
	localparam logic [PERMILLE_W-1:0] STRONG_CLIP_RST = 10'd35;
	localparam logic [LEVEL_W-1:0]    MEAN_LOW_RST    = 8'd108;
	localparam logic [LEVEL_W-1:0]    MEAN_HIGH_RST   = 8'd148;

	// verdict codes
	localparam logic [1:0] VERDICT_UNBALANCED = 2'd0;
	localparam logic [1:0] VERDICT_STRONG     = 2'd1;
	localparam logic [1:0] VERDICT_BALANCED   = 2'd2;

	typedef struct packed {
		logic [PERMILLE_W-1:0] clip_floor;
		logic [PERMILLE_W-1:0] strong_clip;
		logic [LEVEL_W-1:0]    mean_low;
		logic [LEVEL_W-1:0]    mean_high;
	} thresh_t;

endpackage

// ===== design/exposure_statistics_check_unit.sv =====
// ----------------------------------------------------------------------------
// exposure_statistics_check_unit: exposure balance check over a frame set
// Takes one pixel word per cycle unless stalled, gathers clip counts and level
// sums per channel and emits one verdict word after the last pixel of each set.
// ----------------------------------------------------------------------------
// Throughput: one pixel word per cycle; last pixels may also come back to back.
// Path: the set moves through the snapshot, product and compare registers;
//   the snapshot loads on the edge that takes the last pixel, out_valid marks the compare register.
// Up to three verdicts queue in the pipeline; pixels stall only when it fills.
// Reset (arst_n low) clears all counters and the valid flags of the pipeline and output, and
//   loads the threshold registers with 10, 35, 108 and 148.
module exposure_statistics_check_unit import esc_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// pixel channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [LEVEL_W-1:0]     blue_level,
	input  logic [LEVEL_W-1:0]     green_level,
	input  logic [LEVEL_W-1:0]     red_level,
	input  logic                   last_pixel,
	// verdict channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             verdict,
	output logic                   count_overflow
);

	localparam int SW = COUNT_WIDTH + LEVEL_W;

	thresh_t                  thr_q;
	logic                     in_ready;
	logic                     take;
	logic                     snap_take;
	logic                     valid_s1;
	logic [COUNT_WIDTH-1:0]   dark_s1   [NUM_CH];
	logic [COUNT_WIDTH-1:0]   bright_s1 [NUM_CH];
	logic [SW-1:0]            sum_s1    [NUM_CH];
	logic [COUNT_WIDTH-1:0]   total_s1;
	logic                     sat_s1;

	// Threshold registers. The user must let writes arrive only while the block is
	// idle; the block does not enforce it. The evaluator reads them straight, with no shadow copy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.clip_floor  <= CLIP_FLOOR_RST;
			thr_q.strong_clip <= STRONG_CLIP_RST;
			thr_q.mean_low    <= MEAN_LOW_RST;
			thr_q.mean_high   <= MEAN_HIGH_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CLIP_FLOOR:  thr_q.clip_floor  <= cfg_data;
				REG_STRONG_CLIP: thr_q.strong_clip <= cfg_data;
				REG_MEAN_LOW:    thr_q.mean_low    <= cfg_data[LEVEL_W-1:0];
				REG_MEAN_HIGH:   thr_q.mean_high   <= cfg_data[LEVEL_W-1:0];
				default:         thr_q             <= thr_q;
			endcase
		end
	end

	// Hold pixels only when the snapshot stage still holds a set that the
	// evaluator cannot take; ordinary pixels just accumulate.
	assign in_stall = !in_ready;
	assign take     = in_valid && in_ready;

	// Accumulate the running statistics and snapshot them on the last pixel.
	esc_accum #(
		.CW (COUNT_WIDTH)
	) u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.blue_level  (blue_level),
		.green_level (green_level),
		.red_level   (red_level),
		.last_pixel  (last_pixel),
		.snap_take   (snap_take),
		.in_ready    (in_ready),
		.valid_s1    (valid_s1),
		.dark_s1     (dark_s1),
		.bright_s1   (bright_s1),
		.sum_s1      (sum_s1),
		.total_s1    (total_s1),
		.sat_s1      (sat_s1)
	);

	// Evaluate the snapshot: products first, then compares into the output
	// register, which advances whenever the consumer does not stall.
	esc_eval #(
		.CW (COUNT_WIDTH)
	) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.thr        (thr_q),
		.valid_s1   (valid_s1),
		.dark_s1    (dark_s1),
		.bright_s1  (bright_s1),
		.sum_s1     (sum_s1),
		.total_s1   (total_s1),
		.sat_s1     (sat_s1),
		.snap_take  (snap_take),
		.res_stall  (out_stall),
		.valid_s3   (out_valid),
		.verdict_s3 (verdict),
		.ovf_s3     (count_overflow)
	);

endmodule

// ===== design/esc_accum.sv =====
// ----------------------------------------------------------------------------
// esc_accum: per-set pixel statistics
// Counts dark and bright samples per channel, sums levels and counts pixels,
// all saturating. On the last pixel the final totals go to a snapshot stage
// and the running state clears.
// ----------------------------------------------------------------------------
module esc_accum import esc_pkg::*; #(
	parameter int CW = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic [LEVEL_W-1:0]    blue_level,
	input  logic [LEVEL_W-1:0]    green_level,
	input  logic [LEVEL_W-1:0]    red_level,
	input  logic                  last_pixel,
	input  logic                  snap_take,
	output logic                  in_ready,
	output logic                  valid_s1,
	output logic [CW-1:0]         dark_s1   [NUM_CH],
	output logic [CW-1:0]         bright_s1 [NUM_CH],
	output logic [CW+LEVEL_W-1:0] sum_s1    [NUM_CH],
	output logic [CW-1:0]         total_s1,
	output logic                  sat_s1
);

	localparam int SW = CW + LEVEL_W;

	logic [LEVEL_W-1:0] lvl [NUM_CH];
	logic [CW-1:0]      dark_q   [NUM_CH];
	logic [CW-1:0]      bright_q [NUM_CH];
	logic [SW-1:0]      sum_q    [NUM_CH];
	logic [CW-1:0]      total_q;
	logic               sat_q;

	logic [CW-1:0]      dark_nxt   [NUM_CH];
	logic [CW-1:0]      bright_nxt [NUM_CH];
	logic [SW-1:0]      sum_nxt    [NUM_CH];
	logic [CW-1:0]      total_nxt;
	logic               sat_nxt;
	logic [SW:0]        sum_wide   [NUM_CH];
	logic               snap_free;

	assign lvl[0] = blue_level;
	assign lvl[1] = green_level;
	assign lvl[2] = red_level;

	assign snap_free = !valid_s1 || snap_take;
	assign in_ready  = snap_free;

	always_comb begin
		sat_nxt = sat_q;
		for (int c = 0; c < NUM_CH; c++) begin
			dark_nxt[c]   = dark_q[c];
			bright_nxt[c] = bright_q[c];
			if (lvl[c] == LEVEL_DARK) begin
				if (&dark_q[c]) sat_nxt = 1'b1;
				else dark_nxt[c] = dark_q[c] + CW'(1);
			end
			if (lvl[c] == LEVEL_BRIGHT) begin
				if (&bright_q[c]) sat_nxt = 1'b1;
				else bright_nxt[c] = bright_q[c] + CW'(1);
			end
			sum_wide[c] = {1'b0, sum_q[c]} + {{(SW + 1 - LEVEL_W){1'b0}}, lvl[c]};
			if (sum_wide[c][SW]) begin
				sat_nxt    = 1'b1;
				sum_nxt[c] = '1;
			end else begin
				sum_nxt[c] = sum_wide[c][SW-1:0];
			end
		end
		if (&total_q) begin
			sat_nxt   = 1'b1;
			total_nxt = total_q;
		end else begin
			total_nxt = total_q + CW'(1);
		end
	end

	// running state: clear on the last pixel of a set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				dark_q[c]   <= '0;
				bright_q[c] <= '0;
				sum_q[c]    <= '0;
			end
			total_q <= '0;
			sat_q   <= 1'b0;
		end else if (take) begin
			if (last_pixel) begin
				for (int c = 0; c < NUM_CH; c++) begin
					dark_q[c]   <= '0;
					bright_q[c] <= '0;
					sum_q[c]    <= '0;
				end
				total_q <= '0;
				sat_q   <= 1'b0;
			end else begin
				dark_q   <= dark_nxt;
				bright_q <= bright_nxt;
				sum_q    <= sum_nxt;
				total_q  <= total_nxt;
				sat_q    <= sat_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (snap_free) begin
			valid_s1 <= take && last_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_free && take && last_pixel) begin
			dark_s1   <= dark_nxt;
			bright_s1 <= bright_nxt;
			sum_s1    <= sum_nxt;
			total_s1  <= total_nxt;
			sat_s1    <= sat_nxt;
		end
	end

endmodule

// ===== design/esc_eval.sv =====
// ----------------------------------------------------------------------------
// esc_eval: verdict evaluation
// First stage forms the threshold products and the grand sum, second stage
// compares and registers the verdict word for the output channel.
// ----------------------------------------------------------------------------
module esc_eval import esc_pkg::*; #(
	parameter int CW = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  thresh_t               thr,
	input  logic                  valid_s1,
	input  logic [CW-1:0]         dark_s1   [NUM_CH],
	input  logic [CW-1:0]         bright_s1 [NUM_CH],
	input  logic [CW+LEVEL_W-1:0] sum_s1    [NUM_CH],
	input  logic [CW-1:0]         total_s1,
	input  logic                  sat_s1,
	output logic                  snap_take,
	input  logic                  res_stall,
	output logic                  valid_s3,
	output logic [1:0]            verdict_s3,
	output logic                  ovf_s3
);

	localparam int SW = CW + LEVEL_W;
	localparam int PW = CW + PERMILLE_W;
	localparam int AW = SW + 2;

	logic          valid_s2;
	logic [PW-1:0] dark_s2   [NUM_CH];
	logic [PW-1:0] bright_s2 [NUM_CH];
	logic [SW-1:0] sum_s2    [NUM_CH];
	logic [PW-1:0] floor_s2;
	logic [PW-1:0] strong_s2;
	logic [SW-1:0] lo_s2;
	logic [SW-1:0] hi_s2;
	logic [AW-1:0] all_s2;
	logic          sat_s2;

	logic          s3_free;
	logic          s2_free;
	logic [AW-1:0] lo3;
	logic [AW-1:0] hi3;
	logic          floor_ok;
	logic          strong_ok;
	logic          band_ok;
	logic [1:0]    verdict_nxt;

	assign s3_free   = !valid_s3 || !res_stall;
	assign s2_free   = !valid_s2 || s3_free;
	assign snap_take = s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	// products: clip counts scaled to per-mille, thresholds times pixel count
	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			for (int c = 0; c < NUM_CH; c++) begin
				dark_s2[c]   <= PW'(dark_s1[c]) * PW'(PERMILLE_SCALE);
				bright_s2[c] <= PW'(bright_s1[c]) * PW'(PERMILLE_SCALE);
			end
			sum_s2    <= sum_s1;
			floor_s2  <= PW'(thr.clip_floor) * PW'(total_s1);
			strong_s2 <= PW'(thr.strong_clip) * PW'(total_s1);
			lo_s2     <= SW'(thr.mean_low) * SW'(total_s1);
			hi_s2     <= SW'(thr.mean_high) * SW'(total_s1);
			all_s2    <= AW'(sum_s1[0]) + AW'(sum_s1[1]) + AW'(sum_s1[2]);
			sat_s2    <= sat_s1;
		end
	end

	always_comb begin
		lo3       = {1'b0, lo_s2, 1'b0} + AW'(lo_s2);
		hi3       = {1'b0, hi_s2, 1'b0} + AW'(hi_s2);
		floor_ok  = 1'b1;
		strong_ok = 1'b1;
		band_ok   = (all_s2 > lo3) && (all_s2 < hi3);
		for (int c = 0; c < NUM_CH; c++) begin
			if (!(dark_s2[c] > floor_s2) || !(bright_s2[c] > floor_s2)) floor_ok = 1'b0;
			if (!(dark_s2[c] > strong_s2) || !(bright_s2[c] > strong_s2)) strong_ok = 1'b0;
			if (!(sum_s2[c] > lo_s2) || !(sum_s2[c] < hi_s2)) band_ok = 1'b0;
		end
		priority if (!(floor_ok && band_ok)) verdict_nxt = VERDICT_UNBALANCED;
		else if (strong_ok) verdict_nxt = VERDICT_STRONG;
		else verdict_nxt = VERDICT_BALANCED;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && valid_s2) begin
			verdict_s3 <= verdict_nxt;
			ovf_s3     <= sat_s2;
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for exposure_statistics_check_unit
// Streams pixel words through the block across several threshold settings and
// compares every verdict word against an in-bench model of the clip counters,
// level sums and balance tests, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
	import esc_pkg::*;

	// run the block with a 16-bit counter width
	localparam int CNT_W        = 16;
	localparam int SETTLE       = 8;     // pipeline is three deep; leave margin
	localparam int DEAD_LIMIT   = 5000;
	localparam int RANDOM_WORDS = 1600;
	localparam int RANDOM_PHASES = 8;
	localparam longint unsigned COUNT_MAX = (64'd1 << CNT_W) - 64'd1;
	localparam longint unsigned SUM_MAX   = (64'd1 << (CNT_W + LEVEL_W)) - 64'd1;

	typedef struct packed {
		logic [LEVEL_W-1:0] blue;
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] red;
		logic               last;
	} pixel_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic       overflow;
	} verdict_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [LEVEL_W-1:0]     blue_level = '0;
	logic [LEVEL_W-1:0]     green_level = '0;
	logic [LEVEL_W-1:0]     red_level = '0;
	logic                   last_pixel = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [1:0]             verdict;
	logic                   count_overflow;

	exposure_statistics_check_unit #(
		.COUNT_WIDTH(CNT_W)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.blue_level    (blue_level),
		.green_level   (green_level),
		.red_level     (red_level),
		.last_pixel    (last_pixel),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.verdict       (verdict),
		.count_overflow(count_overflow)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Exposure model: its own copy of the thresholds and the set statistics
	// ------------------------------------------------------------------------
	logic [PERMILLE_W-1:0] floor_pm  = CLIP_FLOOR_RST;
	logic [PERMILLE_W-1:0] strong_pm = STRONG_CLIP_RST;
	logic [LEVEL_W-1:0]    band_lo   = MEAN_LOW_RST;
	logic [LEVEL_W-1:0]    band_hi   = MEAN_HIGH_RST;

	longint unsigned dark_n [NUM_CH];
	longint unsigned bright_n [NUM_CH];
	longint unsigned level_sum [NUM_CH];
	longint unsigned pixel_n;
	bit              saturated;

	pixel_t   pixel_q[$];     // words waiting for the driver
	verdict_t verdict_q[$];   // verdicts owed by the block, oldest first

	bit no_breaks = 1'b0;     // set during the long stretch with no idling
	int mismatches = 0;
	int words_in = 0;
	int words_out = 0;
	int dead_cycles = 0;
	int settings_run = 0;
	int sat_sets = 0;
	int verdict_hist [3];

	// Saturating increment; flag the set once a counter pins.
	function automatic longint unsigned count_up(input longint unsigned v);
		if (v >= COUNT_MAX) begin
			saturated = 1'b1;
			return COUNT_MAX;
		end
		return v + 64'd1;
	endfunction

	// Both clip fractions of every channel strictly above pm per mille.
	function automatic bit clipped_above(input longint unsigned pm);
		longint unsigned lim;
		int c;
		lim = pm * pixel_n;
		for (c = 0; c < NUM_CH; c++) begin
			if (dark_n[c] * PERMILLE_SCALE <= lim) return 1'b0;
			if (bright_n[c] * PERMILLE_SCALE <= lim) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Fold one accepted pixel word into the statistics; on the last pixel
	// judge the set, queue the verdict it owes and start a fresh set.
	task automatic tally_pixel(input pixel_t p);
		logic [LEVEL_W-1:0] lv [NUM_CH];
		longint unsigned lo, hi, all;
		bit balanced;
		verdict_t res;
		int c;
		lv[0] = p.blue;
		lv[1] = p.green;
		lv[2] = p.red;
		for (c = 0; c < NUM_CH; c++) begin
			if (lv[c] == LEVEL_DARK) dark_n[c] = count_up(dark_n[c]);
			if (lv[c] == LEVEL_BRIGHT) bright_n[c] = count_up(bright_n[c]);
			if (level_sum[c] > SUM_MAX - lv[c]) begin
				saturated = 1'b1;
				level_sum[c] = SUM_MAX;
			end else begin
				level_sum[c] = level_sum[c] + lv[c];
			end
		end
		pixel_n = count_up(pixel_n);
		if (p.last) begin
			lo = band_lo * pixel_n;
			hi = band_hi * pixel_n;
			balanced = clipped_above(floor_pm);
			all = 0;
			for (c = 0; c < NUM_CH; c++) begin
				if (!(level_sum[c] > lo && level_sum[c] < hi)) balanced = 1'b0;
				all = all + level_sum[c];
			end
			if (!(all > 3 * lo && all < 3 * hi)) balanced = 1'b0;
			if (!balanced) res.verdict = VERDICT_UNBALANCED;
			else if (clipped_above(strong_pm)) res.verdict = VERDICT_STRONG;
			else res.verdict = VERDICT_BALANCED;
			res.overflow = saturated;
			verdict_q.insert(verdict_q.size(), res);
			verdict_hist[res.verdict]++;
			if (saturated) sat_sets++;
			for (c = 0; c < NUM_CH; c++) begin
				dark_n[c] = 0;
				bright_n[c] = 0;
				level_sum[c] = 0;
			end
			pixel_n = 0;
			saturated = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Random idle decision shared by both sides: a 36 in 100 chance per call.
	function automatic bit take_break();
		return !no_breaks && ($urandom_range(0, 99) < 36);
	endfunction

	// ------------------------------------------------------------------------
	// Pixel driver: present a new word only when the slot is free, hold it
	// unchanged while stalled, and feed each accepted word to the model.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : pixel_driver
		pixel_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				tally_pixel({blue_level, green_level, red_level, last_pixel});
				words_in++;
			end
			if (!in_valid || !in_stall) begin
				if (pixel_q.size() != 0 && !take_break()) begin
					nxt = pixel_q.pop_front();
					in_valid    <= 1'b1;
					blue_level  <= nxt.blue;
					green_level <= nxt.green;
					red_level   <= nxt.red;
					last_pixel  <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Verdict monitor: check each accepted word against the oldest verdict
	// owed, then roll the stall for the next cycle.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : verdict_monitor
		verdict_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				words_out++;
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("verdict word %0d/%0d with none owed",
						verdict, count_overflow));
				end else begin
					want = verdict_q.pop_front();
					if (verdict !== want.verdict)
						report_mismatch($sformatf("verdict got %0d, expected %0d",
							verdict, want.verdict));
					if (count_overflow !== want.overflow)
						report_mismatch($sformatf("count_overflow got %0d, expected %0d",
							count_overflow, want.overflow));
				end
			end
			out_stall <= take_break();
		end
	end

	// Watchdog: end the run if nothing moves on any port for too long.
	always @(posedge clk) begin : watchdog
		if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			dead_cycles <= 0;
		end else if (dead_cycles >= DEAD_LIMIT) begin
			$display("[%0t] watchdog: no word moved for %0d cycles, %0d verdicts still owed",
				$time, DEAD_LIMIT, verdict_q.size());
			$display("TEST FAILED");
			$finish;
		end else begin
			dead_cycles <= dead_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_pixel(input logic [LEVEL_W-1:0] b, input logic [LEVEL_W-1:0] g,
		input logic [LEVEL_W-1:0] r, input logic last);
		pixel_t p;
		p.blue  = b;
		p.green = g;
		p.red   = r;
		p.last  = last;
		pixel_q.insert(pixel_q.size(), p);
	endtask

	// Write one register at a clock edge and mirror it in the model.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_CLIP_FLOOR: begin
				floor_pm = data;
			end
			REG_STRONG_CLIP: begin
				strong_pm = data;
			end
			REG_MEAN_LOW: begin
				band_lo = data[LEVEL_W-1:0];
			end
			REG_MEAN_HIGH: begin
				band_hi = data[LEVEL_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Load a full threshold setting; the band registers keep only 8 bits,
	// so any upper bits in the data are dropped by the block.
	task automatic set_thresholds(input logic [CFG_DATA_W-1:0] fl,
		input logic [CFG_DATA_W-1:0] st, input logic [CFG_DATA_W-1:0] lo,
		input logic [CFG_DATA_W-1:0] hi);
		write_reg(REG_CLIP_FLOOR, fl);
		write_reg(REG_STRONG_CLIP, st);
		write_reg(REG_MEAN_LOW, lo);
		write_reg(REG_MEAN_HIGH, hi);
		settings_run++;
		@(negedge clk);
	endtask

	// Wait until every word has gone in and every verdict has come back,
	// then let the pipeline drain before touching the registers.
	task automatic settle();
		do @(negedge clk);
		while (pixel_q.size() != 0 || in_valid || verdict_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Clip to dark or bright with clip_pm per mille each; otherwise scatter
	// around the center, staying off the clip levels.
	function automatic logic [LEVEL_W-1:0] draw_level(input int clip_pm, input int center,
		input int spread);
		int r, v;
		r = $urandom_range(0, 999);
		if (r < clip_pm) return LEVEL_DARK;
		if (r < 2 * clip_pm) return LEVEL_BRIGHT;
		v = $urandom_range(0, 2 * spread);
		v = center + v - spread;
		if (v < 1) v = 1;
		if (v > 254) v = 254;
		return v[LEVEL_W-1:0];
	endfunction

	// A set built to land near the band with real clipping at both ends,
	// so the balance tests are decided by the details.
	task automatic push_shaped_set(input int n);
		int clip_pm, center, spread, i;
		clip_pm = $urandom_range(5, 200);
		center = band_lo + band_hi;
		center = center / 2;
		if (center < 20) center = 20;
		if (center > 235) center = 235;
		spread = $urandom_range(0, 40);
		for (i = 0; i < n; i++)
			push_pixel(draw_level(clip_pm, center, spread), draw_level(clip_pm, center, spread),
				draw_level(clip_pm, center, spread), i == n - 1);
	endtask

	task automatic push_noise_set(input int n);
		int i;
		for (i = 0; i < n; i++)
			push_pixel(LEVEL_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)),
				LEVEL_W'($urandom_range(0, 255)), i == n - 1);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : sequencer
		int k, n, phase_words, phase_sets;
		logic [CFG_DATA_W-1:0] fl, st, lo, hi;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset thresholds. Single-pixel sets can never clear the floor.
		push_pixel(LEVEL_DARK, LEVEL_BRIGHT, LEVEL_DARK, 1'b1);
		push_pixel(LEVEL_BRIGHT, LEVEL_DARK, LEVEL_BRIGHT, 1'b1);
		// Balanced with heavy clipping in every channel.
		push_pixel(8'd0, 8'd255, 8'd128, 1'b0);
		push_pixel(8'd255, 8'd128, 8'd0, 1'b0);
		push_pixel(8'd128, 8'd0, 8'd255, 1'b0);
		push_pixel(8'd128, 8'd128, 8'd128, 1'b1);
		// All channels far above the band.
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		// Only red leaves the band.
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		push_pixel(8'd128, 8'd128, 8'd200, 1'b0);
		push_pixel(8'd128, 8'd128, 8'd200, 1'b1);
		// Last pixels back to back.
		push_pixel(8'd1, 8'd254, 8'd127, 1'b1);
		push_pixel(8'd128, 8'd128, 8'd128, 1'b1);
		push_pixel(8'd254, 8'd1, 8'd0, 1'b1);
		settle();

		// Zero floor, strong threshold above 1000: never strong, balanced only where every channel clips.
		set_thresholds(10'd0, 10'd1023, 10'd0, 10'd255);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		push_pixel(8'd0, 8'd255, 8'd127, 1'b0);
		push_pixel(8'd255, 8'd0, 8'd128, 1'b1);
		settle();

		// Floor above 1000: the clip test can never pass.
		set_thresholds(10'd1023, 10'd0, 10'd0, 10'd255);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		settle();

		// Inverted band, then an empty band of zero width.
		set_thresholds(10'd0, 10'd0, 10'd200, 10'd100);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		settle();
		set_thresholds(10'd0, 10'd0, 10'd128, 10'd128);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		settle();

		// Random phases: mostly shaped sets, the rest noise, each phase
		// under its own threshold setting. The first phase runs at full
		// rate with no idling on either side.
		for (k = 0; k < RANDOM_PHASES; k++) begin
			case (k)
				0: begin
					fl = CLIP_FLOOR_RST;
					st = STRONG_CLIP_RST;
					lo = MEAN_LOW_RST;
					hi = MEAN_HIGH_RST;
				end
				1: begin
					fl = 10'd0;
					st = 10'd0;
					lo = 10'd0;
					hi = 10'd255;
				end
				2: begin
					fl = 10'h3FF;
					st = 10'h3FF;
					lo = 10'h3FF;
					hi = 10'h300;
				end
				default: begin
					fl = CFG_DATA_W'($urandom_range(0, 60));
					st = CFG_DATA_W'($urandom_range(fl, 200));
					lo = CFG_DATA_W'(($urandom_range(0, 3) << LEVEL_W)
						| $urandom_range(80, 127));
					hi = CFG_DATA_W'(($urandom_range(0, 3) << LEVEL_W)
						| $urandom_range(129, 200));
				end
			endcase
			set_thresholds(fl, st, lo, hi);
			no_breaks = (k == 0);
			phase_words = 0;
			phase_sets = 0;
			while (phase_words < RANDOM_WORDS / RANDOM_PHASES || phase_sets < 6) begin
				if ($urandom_range(0, 3) == 0) begin
					n = $urandom_range(1, 16);
					push_noise_set(n);
				end else begin
					n = $urandom_range(4, 48);
					push_shaped_set(n);
				end
				phase_words += n;
				phase_sets++;
			end
			settle();
			no_breaks = 1'b0;
		end

		repeat (SETTLE) @(posedge clk);
		if (verdict_q.size() != 0)
			report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
		$display("Covered %0d pixel words and %0d verdict words over %0d threshold settings.",
			words_in, words_out, settings_run + 1);
		$display("Verdicts: %0d unbalanced, %0d strong clipping, %0d balanced; %0d saturated.",
			verdict_hist[0], verdict_hist[1], verdict_hist[2], sat_sets);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
